// ===== rtl/ifm_pkg.sv =====
`timescale 1ns / 1ps

package ifm_pkg;

  localparam logic [1:0] ModeEntry  = 2'd0;
  localparam logic [1:0] ModeHeader = 2'd1;
  localparam logic [1:0] ModeCheck  = 2'd2;

  typedef enum logic [1:0] {
    KindNotInRange = 2'd0,
    KindInRange    = 2'd1,
    KindNotEqual   = 2'd2,
    KindEqual      = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] low;
    logic [31:0] high;
  } entry_t;

endpackage

// ===== rtl/ip_flow_list_matcher.sv =====
// A check transfer passes the header and entry RAM reads, the list compare registers and the verdict register.
// Throughput: one item per cycle; input stalls while a result waits or the header clear runs.
// Entry and header writes take effect for a check accepted in the next cycle.
// Reset: control state clears at once, then the rule headers are cleared
// one rule after another, during which in_ready_o stays low.
`timescale 1ns / 1ps

module ip_flow_list_matcher import ifm_pkg::*; #(
  parameter int RULES   = 64,
  parameter int ENTRIES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [5:0]  rule_index_i,
  input  logic        list_side_i,
  input  logic [2:0]  slot_index_i,
  input  logic [1:0]  entry_kind_i,
  input  logic [31:0] range_low_i,
  input  logic [31:0] range_high_i,
  input  logic        swap_sides_i,
  input  logic [3:0]  entry_count_i,
  input  logic [31:0] source_addr_i,
  input  logic [31:0] dest_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        matched_o,
  output logic [5:0]  rule_echo_o
);

  localparam int RuleAw = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int CntW   = $clog2(ENTRIES + 1);
  localparam int EntryW = $bits(entry_t);

  logic              adv, accept, rule_ok, slot_ok, ent_we;
  logic [RuleAw-1:0] rule_addr, hdr_waddr;
  logic              hdr_we, src_cnt_we, dst_cnt_we;
  logic [CntW-1:0]   cnt_sat, cnt_wdata;
  logic              swap_wdata;
  entry_t            ent_wdata;

  logic              clr_q, clr_d;
  logic [RuleAw-1:0] clr_addr_q, clr_addr_d;

  logic              v1_q, v2_q, out_valid_q;
  logic [5:0]        rule1_q, rule2_q, rule_echo_q;
  logic              ok1_q, ok2_q, ok3_q;
  logic [31:0]       src1_q, dst1_q;

  logic              swap_rd;
  logic [CntW-1:0]   src_cnt_rd, dst_cnt_rd;
  entry_t            src_ent [ENTRIES];
  entry_t            dst_ent [ENTRIES];
  logic [31:0]       addr_a, addr_b;
  logic              src_pass, dst_pass;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv && !clr_q;
  assign accept     = in_valid_i && in_ready_o;

  assign rule_ok   = (32'(rule_index_i) < RULES);
  assign slot_ok   = (32'(slot_index_i) < ENTRIES);
  assign rule_addr = RuleAw'(rule_index_i);

  assign ent_we    = accept && (mode_i == ModeEntry) && rule_ok && slot_ok;
  assign ent_wdata = '{kind: kind_e'(entry_kind_i), low: range_low_i, high: range_high_i};

  assign hdr_we     = clr_q || (accept && (mode_i == ModeHeader) && rule_ok);
  assign hdr_waddr  = clr_q ? clr_addr_q : rule_addr;
  assign src_cnt_we = hdr_we && (clr_q || !list_side_i);
  assign dst_cnt_we = hdr_we && (clr_q || list_side_i);
  assign cnt_sat    = (32'(entry_count_i) > ENTRIES) ? CntW'(ENTRIES) : CntW'(entry_count_i);
  assign cnt_wdata  = clr_q ? '0 : cnt_sat;
  assign swap_wdata = clr_q ? 1'b0 : swap_sides_i;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      if (clr_addr_q == RuleAw'(RULES - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      if (adv) begin
        v1_q        <= accept && (mode_i == ModeCheck);
        v2_q        <= v1_q;
        out_valid_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rule1_q     <= rule_index_i;
      ok1_q       <= rule_ok;
      src1_q      <= source_addr_i;
      dst1_q      <= dest_addr_i;
      rule2_q     <= rule1_q;
      ok2_q       <= ok1_q;
      rule_echo_q <= rule2_q;
      ok3_q       <= ok2_q;
    end
  end

  ifm_ram #(.Width(1), .Depth(RULES)) u_swap_ram (
    .clk_i   (clk_i),
    .we_i    (hdr_we),
    .waddr_i (hdr_waddr),
    .wdata_i (swap_wdata),
    .re_i    (adv),
    .raddr_i (rule_addr),
    .rdata_o (swap_rd)
  );

  ifm_ram #(.Width(CntW), .Depth(RULES)) u_src_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (src_cnt_we),
    .waddr_i (hdr_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (adv),
    .raddr_i (rule_addr),
    .rdata_o (src_cnt_rd)
  );

  ifm_ram #(.Width(CntW), .Depth(RULES)) u_dst_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (dst_cnt_we),
    .waddr_i (hdr_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (adv),
    .raddr_i (rule_addr),
    .rdata_o (dst_cnt_rd)
  );

  for (genvar k = 0; k < ENTRIES; k++) begin : g_slot
    logic [EntryW-1:0] src_rd, dst_rd;

    ifm_ram #(.Width(EntryW), .Depth(RULES)) u_src_ram (
      .clk_i   (clk_i),
      .we_i    (ent_we && !list_side_i && (32'(slot_index_i) == k)),
      .waddr_i (rule_addr),
      .wdata_i (ent_wdata),
      .re_i    (adv),
      .raddr_i (rule_addr),
      .rdata_o (src_rd)
    );

    ifm_ram #(.Width(EntryW), .Depth(RULES)) u_dst_ram (
      .clk_i   (clk_i),
      .we_i    (ent_we && list_side_i && (32'(slot_index_i) == k)),
      .waddr_i (rule_addr),
      .wdata_i (ent_wdata),
      .re_i    (adv),
      .raddr_i (rule_addr),
      .rdata_o (dst_rd)
    );

    assign src_ent[k] = entry_t'(src_rd);
    assign dst_ent[k] = entry_t'(dst_rd);
  end

  assign addr_a = swap_rd ? dst1_q : src1_q;
  assign addr_b = swap_rd ? src1_q : dst1_q;

  ifm_list_match #(.Entries(ENTRIES), .CntW(CntW)) u_src_list (
    .clk_i     (clk_i),
    .en_i      (adv),
    .entries_i (src_ent),
    .count_i   (src_cnt_rd),
    .addr_i    (addr_a),
    .pass_o    (src_pass)
  );

  ifm_list_match #(.Entries(ENTRIES), .CntW(CntW)) u_dst_list (
    .clk_i     (clk_i),
    .en_i      (adv),
    .entries_i (dst_ent),
    .count_i   (dst_cnt_rd),
    .addr_i    (addr_b),
    .pass_o    (dst_pass)
  );

  assign out_valid_o = out_valid_q;
  assign matched_o   = ok3_q && src_pass && dst_pass;
  assign rule_echo_o = rule_echo_q;

  a_check_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode_i == ModeCheck) |=> v1_q)
    else $error("accepted check did not enter the pipeline");

  a_write_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode_i != ModeCheck) |=> !v1_q)
    else $error("write transfer produced a pipeline slot");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v1_q) && $stable(v2_q) && $stable(rule2_q))
    else $error("pipeline moved during a stall");

  a_clear_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_q) |-> $past(clr_addr_q) == RuleAw'(RULES - 1))
    else $error("header clear ended early");

endmodule

// ===== rtl/ifm_ram.sv =====
`timescale 1ns / 1ps

module ifm_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ifm_list_match.sv =====
`timescale 1ns / 1ps

module ifm_list_match import ifm_pkg::*; #(
  parameter int Entries = 8,
  parameter int CntW    = 4
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  entry_t          entries_i [Entries],
  input  logic [CntW-1:0] count_i,
  input  logic [31:0]     addr_i,
  output logic            pass_o
);

  logic [Entries-1:0] hit_d, pos_d, act_d;
  logic [Entries-1:0] hit_q, pos_q, act_q;
  logic               neg_hit, has_pos, pos_hit;
  logic               pass_q;

  always_comb begin
    for (int k = 0; k < Entries; k++) begin
      if (entries_i[k].kind == KindNotEqual || entries_i[k].kind == KindEqual) begin
        hit_d[k] = (addr_i == entries_i[k].low);
      end else begin
        hit_d[k] = (addr_i > entries_i[k].low) && (addr_i < entries_i[k].high);
      end
      pos_d[k] = (entries_i[k].kind == KindInRange) || (entries_i[k].kind == KindEqual);
      act_d[k] = (k < 32'(count_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= hit_d;
      pos_q <= pos_d;
      act_q <= act_d;
    end
  end

  assign neg_hit = |(act_q & hit_q & ~pos_q);
  assign has_pos = |(act_q & pos_q);
  assign pos_hit = |(act_q & pos_q & hit_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pass_q <= !neg_hit && (!has_pos || pos_hit);
    end
  end

  assign pass_o = pass_q;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ifm_pkg::*;

  localparam int Rules = 64;
  localparam int Entries = 8;
  localparam logic [1:0] ModeUnused = 2'd3;

  typedef struct {
    logic [1:0]  mode;
    logic [5:0]  rule;
    logic        side;
    logic [2:0]  slot;
    kind_e       kind;
    logic [31:0] low;
    logic [31:0] high;
    logic        swap;
    logic [3:0]  count;
    logic [31:0] src;
    logic [31:0] dst;
  } flow_item_t;

  typedef struct {
    logic       matched;
    logic [5:0] rule;
  } verdict_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  mode_i;
  logic [5:0]  rule_index_i;
  logic        list_side_i;
  logic [2:0]  slot_index_i;
  logic [1:0]  entry_kind_i;
  logic [31:0] range_low_i;
  logic [31:0] range_high_i;
  logic        swap_sides_i;
  logic [3:0]  entry_count_i;
  logic [31:0] source_addr_i;
  logic [31:0] dest_addr_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        matched_o;
  logic [5:0]  rule_echo_o;

  logic [31:0] low_tab  [Rules][2][Entries];
  logic [31:0] high_tab [Rules][2][Entries];
  kind_e       kind_tab [Rules][2][Entries];
  bit          written_tab [Rules][2][Entries];
  bit          swap_tab [Rules];
  logic [3:0]  count_tab [Rules][2];

  verdict_t verdict_q[$];

  bit idle_in;
  bit idle_out;
  int hold_request;
  int errors;
  int mismatches;
  int writes_sent;
  int checks_sent;
  int matches_predicted;
  int results_seen;

  ip_flow_list_matcher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .rule_index_i  (rule_index_i),
    .list_side_i   (list_side_i),
    .slot_index_i  (slot_index_i),
    .entry_kind_i  (entry_kind_i),
    .range_low_i   (range_low_i),
    .range_high_i  (range_high_i),
    .swap_sides_i  (swap_sides_i),
    .entry_count_i (entry_count_i),
    .source_addr_i (source_addr_i),
    .dest_addr_i   (dest_addr_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .matched_o     (matched_o),
    .rule_echo_o   (rule_echo_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic bit list_passes(int r, int s, logic [31:0] addr);
    bit any_pos;
    bit pos_hit;
    bit neg_hit;
    bit hit;
    kind_e k_kind;
    any_pos = 1'b0;
    pos_hit = 1'b0;
    neg_hit = 1'b0;
    if (count_tab[r][s] == 4'd0) return 1'b1;
    for (int k = 0; k < count_tab[r][s]; k++) begin
      k_kind = kind_tab[r][s][k];
      if (k_kind == KindNotInRange || k_kind == KindInRange) begin
        hit = (addr > low_tab[r][s][k]) && (addr < high_tab[r][s][k]);
      end else begin
        hit = (addr == low_tab[r][s][k]);
      end
      if (k_kind == KindInRange || k_kind == KindEqual) begin
        any_pos = 1'b1;
        if (hit) pos_hit = 1'b1;
      end else if (hit) begin
        neg_hit = 1'b1;
      end
    end
    return !neg_hit && (!any_pos || pos_hit);
  endfunction

  task automatic apply_item(input flow_item_t it);
    verdict_t v;
    logic [31:0] a;
    logic [31:0] b;
    case (it.mode)
      ModeEntry: begin
        low_tab[it.rule][it.side][it.slot] = it.low;
        high_tab[it.rule][it.side][it.slot] = it.high;
        kind_tab[it.rule][it.side][it.slot] = it.kind;
        written_tab[it.rule][it.side][it.slot] = 1'b1;
        writes_sent++;
      end
      ModeHeader: begin
        swap_tab[it.rule] = it.swap;
        count_tab[it.rule][it.side] = (it.count > Entries) ? 4'(Entries) : it.count;
        writes_sent++;
      end
      ModeCheck: begin
        a = swap_tab[it.rule] ? it.dst : it.src;
        b = swap_tab[it.rule] ? it.src : it.dst;
        v.matched = list_passes(it.rule, 0, a) && list_passes(it.rule, 1, b);
        v.rule = it.rule;
        verdict_q.push_back(v);
        checks_sent++;
        if (v.matched) matches_predicted++;
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(input flow_item_t it);
    int gap;
    gap = idle_in ? $urandom_range(0, 4) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i = it.mode;
    rule_index_i = it.rule;
    list_side_i = it.side;
    slot_index_i = it.slot;
    entry_kind_i = it.kind;
    range_low_i = it.low;
    range_high_i = it.high;
    swap_sides_i = it.swap;
    entry_count_i = it.count;
    source_addr_i = it.src;
    dest_addr_i = it.dst;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    apply_item(it);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (verdict_q.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  function automatic flow_item_t rand_item(logic [1:0] mode);
    flow_item_t it;
    it.mode = mode;
    it.rule = 6'($urandom);
    it.side = 1'($urandom);
    it.slot = 3'($urandom);
    it.kind = kind_e'($urandom_range(0, 3));
    it.low = $urandom;
    it.high = $urandom;
    it.swap = 1'($urandom);
    it.count = 4'($urandom);
    it.src = $urandom;
    it.dst = $urandom;
    return it;
  endfunction

  function automatic flow_item_t make_entry(int r, int s, int k, kind_e kind,
                                            logic [31:0] lo, logic [31:0] hi);
    flow_item_t it;
    it = rand_item(ModeEntry);
    it.rule = 6'(r);
    it.side = 1'(s);
    it.slot = 3'(k);
    it.kind = kind;
    it.low = lo;
    it.high = hi;
    return it;
  endfunction

  function automatic flow_item_t make_random_entry(int r, int s, int k);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = $urandom;
    case ($urandom_range(0, 3))
      0: hi = lo + $urandom_range(2, 4000);
      1: hi = $urandom;
      2: begin
        lo = 32'h0;
        hi = 32'hFFFF_FFFF;
      end
      default: hi = lo + 32'd2;
    endcase
    return make_entry(r, s, k, kind_e'($urandom_range(0, 3)), lo, hi);
  endfunction

  function automatic flow_item_t make_header(int r, int s, bit sw, logic [3:0] cnt);
    flow_item_t it;
    it = rand_item(ModeHeader);
    it.rule = 6'(r);
    it.side = 1'(s);
    it.swap = sw;
    it.count = cnt;
    return it;
  endfunction

  function automatic flow_item_t make_check(int r, logic [31:0] src, logic [31:0] dst);
    flow_item_t it;
    it = rand_item(ModeCheck);
    it.rule = 6'(r);
    it.src = src;
    it.dst = dst;
    return it;
  endfunction

  // Addresses are drawn near the bounds of the list that will judge them, so that
  // both hits and misses at the exclusive edges turn up often.
  function automatic logic [31:0] pick_addr(int r, int s);
    int k;
    if (count_tab[r][s] != 4'd0 && $urandom_range(0, 3) != 0) begin
      k = $urandom_range(0, count_tab[r][s] - 1);
      case ($urandom_range(0, 4))
        0: return low_tab[r][s][k];
        1: return low_tab[r][s][k] + 32'd1;
        2: return low_tab[r][s][k] - 32'd1;
        3: return high_tab[r][s][k];
        default: return high_tab[r][s][k] - 32'd1;
      endcase
    end
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Every slot that the new count covers must hold a written entry before the
  // header goes out.
  task automatic program_list(int r, int s, logic [3:0] cnt, bit sw, output int sent);
    int covered;
    covered = (cnt > Entries) ? Entries : int'(cnt);
    sent = 0;
    for (int k = 0; k < covered; k++) begin
      if (!written_tab[r][s][k] || $urandom_range(0, 2) == 0) begin
        send_item(make_random_entry(r, s, k));
        sent++;
      end
    end
    send_item(make_header(r, s, sw, cnt));
    sent++;
  endtask

  task automatic test_any_lists();
    send_item(make_check(0, 32'h0, 32'hFFFF_FFFF));
    send_item(make_check(63, 32'hFFFF_FFFF, 32'h0));
    send_item(make_check(31, $urandom, $urandom));
  endtask

  task automatic test_equality();
    send_item(make_entry(1, 0, 0, KindEqual, 32'hC0A8_0001, 32'hFFFF_FFFF));
    send_item(make_header(1, 0, 1'b0, 4'd1));
    send_item(make_check(1, 32'hC0A8_0001, $urandom));
    send_item(make_check(1, 32'hC0A8_0002, $urandom));
    send_item(make_entry(1, 1, 0, KindNotEqual, 32'h0, 32'h0));
    send_item(make_header(1, 1, 1'b0, 4'd1));
    send_item(make_check(1, 32'hC0A8_0001, 32'h0));
    send_item(make_check(1, 32'hC0A8_0001, 32'h1));
  endtask

  task automatic test_ranges();
    send_item(make_entry(2, 0, 0, KindInRange, 32'd10, 32'd20));
    send_item(make_entry(2, 1, 0, KindNotInRange, 32'h0, 32'hFFFF_FFFF));
    send_item(make_header(2, 0, 1'b0, 4'd1));
    send_item(make_header(2, 1, 1'b0, 4'd1));
    send_item(make_check(2, 32'd10, 32'h0));
    send_item(make_check(2, 32'd11, 32'h0));
    send_item(make_check(2, 32'd20, 32'h0));
    send_item(make_check(2, 32'd19, 32'd5));
    send_item(make_check(2, 32'd19, 32'hFFFF_FFFF));
  endtask

  task automatic test_swap();
    send_item(make_header(1, 0, 1'b1, 4'd1));
    send_item(make_check(1, 32'd5, 32'hC0A8_0001));
    send_item(make_check(1, 32'h0, 32'hC0A8_0001));
  endtask

  task automatic test_count_saturation();
    for (int k = 0; k < Entries; k++) begin
      send_item(make_entry(3, 1, k, KindNotEqual, 32'd100 + k, $urandom));
    end
    send_item(make_header(3, 1, 1'b0, 4'd15));
    send_item(make_check(3, $urandom, 32'd107));
    send_item(make_check(3, $urandom, 32'd108));
  endtask

  task automatic test_ignored_mode();
    send_item(rand_item(ModeUnused));
    send_item(make_check(0, $urandom, $urandom));
  endtask

  task automatic test_backpressure();
    idle_in = 1'b0;
    hold_request = 80;
    for (int i = 0; i < 40; i++) begin
      send_item(make_check($urandom_range(0, 7), pick_addr(0, 0), pick_addr(0, 1)));
    end
    wait_drained();
  endtask

  task automatic test_random(int n);
    int sent;
    int burst;
    int r;
    int s;
    logic [31:0] a;
    logic [31:0] b;
    sent = 0;
    while (sent < n) begin
      if (sent % 100 < 2) begin
        idle_in = ($urandom_range(0, 2) != 0);
        idle_out = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 149) == 0) wait_drained();
      r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, Rules - 1) : $urandom_range(0, 7);
      s = $urandom_range(0, 1);
      case ($urandom_range(0, 99)) inside
        [0:11]: begin
          program_list(r, s, 4'($urandom_range(0, 15)), 1'($urandom), burst);
          sent += burst;
        end
        [12:16]: begin
          send_item(make_random_entry(r, s, $urandom_range(0, Entries - 1)));
          sent++;
        end
        [17:19]: send_item(rand_item(ModeUnused));
        default: begin
          a = pick_addr(r, swap_tab[r] ? 1 : 0);
          b = pick_addr(r, swap_tab[r] ? 0 : 1);
          send_item(make_check(r, a, b));
          sent++;
        end
      endcase
    end
  endtask

  initial begin : result_checker
    verdict_t want;
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      stall = idle_out ? $urandom_range(0, 4) : 0;
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      results_seen++;
      if (verdict_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: matched %0b rule %0d", matched_o, rule_echo_o);
        end
      end else begin
        want = verdict_q.pop_front();
        if (matched_o !== want.matched || rule_echo_o !== want.rule) begin
          errors++;
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected matched %0b rule %0d, got matched %0b rule %0d",
                     want.matched, want.rule, matched_o, rule_echo_o);
          end
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = ModeEntry;
    rule_index_i = '0;
    list_side_i = 1'b0;
    slot_index_i = '0;
    entry_kind_i = KindNotInRange;
    range_low_i = '0;
    range_high_i = '0;
    swap_sides_i = 1'b0;
    entry_count_i = '0;
    source_addr_i = '0;
    dest_addr_i = '0;
    idle_in = 1'b1;
    idle_out = 1'b1;
    hold_request = 0;
    errors = 0;
    mismatches = 0;
    writes_sent = 0;
    checks_sent = 0;
    matches_predicted = 0;
    results_seen = 0;
    for (int r = 0; r < Rules; r++) begin
      swap_tab[r] = 1'b0;
      for (int s = 0; s < 2; s++) begin
        count_tab[r][s] = 4'd0;
        for (int k = 0; k < Entries; k++) written_tab[r][s][k] = 1'b0;
      end
    end
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_any_lists();
    test_equality();
    test_ranges();
    test_swap();
    test_count_saturation();
    test_ignored_mode();
    wait_drained();
    test_backpressure();
    test_random(800);
    wait_drained();

    if (verdict_q.size() != 0) begin
      errors += verdict_q.size();
      $display("%0d expected results never arrived", verdict_q.size());
    end
    $display("summary: %0d table writes and %0d address checks, %0d of them predicted to match;",
             writes_sent, checks_sent, matches_predicted);
    $display("summary: %0d results compared, including a long output stall and sender pauses.",
             results_seen);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
